@@ sv/hlxfr_pkg.sv @@
// Shared types and constants for the header/length/XOR frame receiver.
`timescale 1ns / 1ps

package hlxfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 2;

  localparam logic [ByteW-1:0] HDR0 = 8'h55;  // 'U'
  localparam logic [ByteW-1:0] HDR1 = 8'h4E;  // 'N'
  localparam logic [ByteW-1:0] HDR2 = 8'h45;  // 'E'
  localparam logic [ByteW-1:0] HDR3 = 8'h52;  // 'R'
  localparam logic [ByteW-1:0] SEP  = 8'h3A;  // ':'

  localparam logic [ByteW-1:0] HDR_XOR = HDR0 ^ HDR1 ^ HDR2 ^ HDR3 ^ SEP;

  localparam logic [KindW-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KindW-1:0] KIND_GOOD    = 2'd1;
  localparam logic [KindW-1:0] KIND_BAD     = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_HDR2    = 3'd2,
    PH_HDR3    = 3'd3,
    PH_LEN     = 3'd4,
    PH_SEP     = 3'd5,
    PH_PAYLOAD = 3'd6
  } phase_t;

  typedef struct packed {
    logic             vld;
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] position;
  } res_t;

endpackage

@@ sv/header_length_xor_frame_receiver.sv @@
// Top level of the header/length/XOR frame receiver.
// An accepted word is held in the input register; when it advances, its result, if
//   any, is loaded into the result register, which drives out_valid.
// Throughput: one word per cycle; the input register advances whenever the result
//   register is empty or being drained, so only out_ready stalls the input.
// Reset (synchronous, rst_n low): parser returns to idle, counters and checksum clear,
//   both the input and result registers empty.
`timescale 1ns / 1ps

module header_length_xor_frame_receiver
  import hlxfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] in_rx_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [KindW-1:0] out_kind,
  output logic [ByteW-1:0] out_data,
  output logic [ByteW-1:0] out_position
);

  logic             in_vld_r;
  logic [ByteW-1:0] in_byte_r;
  logic             step;
  res_t             res;

  // advance the held word when the result register can take its result
  assign step     = in_vld_r && (!out_valid || out_ready);
  assign in_ready = !in_vld_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
  end

  hlxfr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_byte_r),
    .res     (res)
  );

  hlxfr_out_reg u_out_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (step),
    .res          (res),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_data     (out_data),
    .out_position (out_position)
  );

endmodule

@@ sv/hlxfr_parser.sv @@
// Frame parser: header match, length count, checksum and result build.
`timescale 1ns / 1ps

module hlxfr_parser
  import hlxfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [ByteW-1:0] rx_byte,
  output res_t             res
);

  phase_t           phase_r, phase_nxt;
  logic [ByteW-1:0] remaining_r, remaining_nxt;
  logic [ByteW-1:0] xor_r, xor_nxt;
  logic [ByteW-1:0] idx_r, idx_nxt;
  logic [ByteW-1:0] rem_dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      remaining_r <= '0;
      xor_r       <= '0;
      idx_r       <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      remaining_r <= remaining_nxt;
      xor_r       <= xor_nxt;
      idx_r       <= idx_nxt;
    end
  end

  assign rem_dec = remaining_r - 8'd1;

  always_comb begin
    phase_nxt     = phase_r;
    remaining_nxt = remaining_r;
    xor_nxt       = xor_r;
    idx_nxt       = idx_r;
    res           = '0;
    // a mismatch retests the same word as a first header word
    case (phase_r)
      PH_HDR1: begin
        if (rx_byte == HDR1) phase_nxt = PH_HDR2;
        else phase_nxt = (rx_byte == HDR0) ? PH_HDR1 : PH_IDLE;
      end
      PH_HDR2: begin
        if (rx_byte == HDR2) phase_nxt = PH_HDR3;
        else phase_nxt = (rx_byte == HDR0) ? PH_HDR1 : PH_IDLE;
      end
      PH_HDR3: begin
        if (rx_byte == HDR3) phase_nxt = PH_LEN;
        else phase_nxt = (rx_byte == HDR0) ? PH_HDR1 : PH_IDLE;
      end
      PH_LEN: begin
        remaining_nxt = rx_byte;
        phase_nxt     = PH_SEP;
      end
      PH_SEP: begin
        if (rx_byte == SEP) begin
          phase_nxt = PH_PAYLOAD;
          idx_nxt   = '0;
          xor_nxt   = HDR_XOR ^ remaining_r;
        end else begin
          phase_nxt = (rx_byte == HDR0) ? PH_HDR1 : PH_IDLE;
        end
      end
      PH_PAYLOAD: begin
        remaining_nxt = rem_dec;
        res.vld       = 1'b1;
        res.position  = idx_r;
        if (rem_dec != '0) begin
          res.kind = KIND_PAYLOAD;
          res.data = rx_byte;
          xor_nxt  = xor_r ^ rx_byte;
          idx_nxt  = idx_r + 8'd1;
        end else begin
          // checksum word closes the frame
          phase_nxt = PH_IDLE;
          res.kind  = (xor_r == rx_byte) ? KIND_GOOD : KIND_BAD;
          res.data  = '0;
        end
      end
      default: begin
        phase_nxt = (rx_byte == HDR0) ? PH_HDR1 : PH_IDLE;
      end
    endcase
  end

endmodule

@@ sv/hlxfr_out_reg.sv @@
// Result register: holds one result word until the consumer takes it.
`timescale 1ns / 1ps

module hlxfr_out_reg
  import hlxfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  res_t             res,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [KindW-1:0] out_kind,
  output logic [ByteW-1:0] out_data,
  output logic [ByteW-1:0] out_position
);

  logic             valid_r;
  logic [KindW-1:0] kind_r;
  logic [ByteW-1:0] data_r;
  logic [ByteW-1:0] pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load && res.vld) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.vld) begin
      kind_r <= res.kind;
      data_r <= res.data;
      pos_r  <= res.position;
    end
  end

  assign out_valid    = valid_r;
  assign out_kind     = kind_r;
  assign out_data     = data_r;
  assign out_position = pos_r;

endmodule

@@ sv/hlxfr_checker.sv @@
// Port-level assertions for the frame receiver, bound to the top level.
`timescale 1ns / 1ps

module hlxfr_checker
  import hlxfr_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [KindW-1:0] out_kind,
  input logic [ByteW-1:0] out_data,
  input logic [ByteW-1:0] out_position
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_data)
      && $stable(out_position))
    else $error("stalled result word changed");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_PAYLOAD || out_kind == KIND_GOOD
      || out_kind == KIND_BAD))
    else $error("result kind out of range");

  a_end_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_PAYLOAD |-> out_data == '0)
    else $error("frame end word carries nonzero data");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind header_length_xor_frame_receiver hlxfr_checker u_hlxfr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_kind     (out_kind),
  .out_data     (out_data),
  .out_position (out_position)
);

@@ tb/hlxfr_frame_checker.sv @@
// Checker for the frame receiver: predicts result words from accepted input bytes and compares.
`timescale 1ns / 1ps

module hlxfr_frame_checker
  import hlxfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [ByteW-1:0] in_rx_byte,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [KindW-1:0] out_kind,
  input  logic [ByteW-1:0] out_data,
  input  logic [ByteW-1:0] out_position,
  output int               fail_count,
  output int               pending_words
);

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] position;
  } frame_word_t;

  frame_word_t      expected_words[$];
  int               mismatches = 0;

  phase_t           parse_phase;
  logic [ByteW-1:0] bytes_left;
  logic [ByteW-1:0] frame_xor;
  logic [ByteW-1:0] payload_count;

  assign fail_count = mismatches;

  // Advance the parser by one received byte; returns 1 when the byte yields a word.
  function automatic bit parse_rx_byte(input logic [ByteW-1:0] b, output frame_word_t word);
    phase_t retest;
    retest = (b == HDR0) ? PH_HDR1 : PH_IDLE;
    word = '0;
    parse_rx_byte = 1'b0;
    case (parse_phase)
      PH_HDR1: parse_phase = (b == HDR1) ? PH_HDR2 : retest;
      PH_HDR2: parse_phase = (b == HDR2) ? PH_HDR3 : retest;
      PH_HDR3: parse_phase = (b == HDR3) ? PH_LEN : retest;
      PH_LEN: begin
        bytes_left  = b;
        parse_phase = PH_SEP;
      end
      PH_SEP: begin
        if (b == SEP) begin
          parse_phase   = PH_PAYLOAD;
          payload_count = '0;
          frame_xor     = HDR_XOR ^ bytes_left;
        end else begin
          parse_phase = retest;
        end
      end
      PH_PAYLOAD: begin
        bytes_left = bytes_left - 8'd1;
        parse_rx_byte = 1'b1;
        if (bytes_left != '0) begin
          word.kind     = KIND_PAYLOAD;
          word.data     = b;
          word.position = payload_count;
          frame_xor     = frame_xor ^ b;
          payload_count = payload_count + 8'd1;
        end else begin
          // checksum byte closes the frame
          parse_phase   = PH_IDLE;
          word.kind     = (frame_xor == b) ? KIND_GOOD : KIND_BAD;
          word.data     = '0;
          word.position = payload_count;
        end
      end
      default: parse_phase = retest;
    endcase
  endfunction

  always @(posedge clk) begin
    frame_word_t exp_word;
    frame_word_t next_word;
    if (!rst_n) begin
      parse_phase   = PH_IDLE;
      bytes_left    = '0;
      frame_xor     = '0;
      payload_count = '0;
      expected_words.delete();
    end else begin
      // a word leaving now always belongs to an earlier byte, so compare first
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected word kind %0d data %h position %0d",
                     $realtime, out_kind, out_data, out_position);
        end else begin
          exp_word = expected_words.pop_front();
          if (exp_word.kind !== out_kind || exp_word.data !== out_data ||
              exp_word.position !== out_position) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: expected kind %0d data %h position %0d, ",
                        "got kind %0d data %h position %0d"},
                       $realtime, exp_word.kind, exp_word.data, exp_word.position,
                       out_kind, out_data, out_position);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (parse_rx_byte(in_rx_byte, next_word))
          expected_words.push_back(next_word);
      end
    end
    pending_words <= expected_words.size();
  end

endmodule

@@ tb/header_length_xor_frame_receiver_tb.sv @@
// Testbench top for the frame receiver: clock, reset, byte stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module header_length_xor_frame_receiver_tb;
  import hlxfr_pkg::*;

  localparam int HalfPeriod  = 10;
  localparam int ResetCycles = 7;
  localparam int HoldCycles  = 80;
  localparam int IdleLimit   = 4000;
  localparam int ByteTarget  = 1000;
  localparam int DrainCycles = 10;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [ByteW-1:0] in_rx_byte = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [KindW-1:0] out_kind;
  logic [ByteW-1:0] out_data;
  logic [ByteW-1:0] out_position;

  int fail_count;
  int pending_words;
  int hold_asked = 0;
  int hold_done = 0;
  int burst_left = 0;
  int bytes_sent = 0;
  int idle_cycles = 0;

  always begin
    #(HalfPeriod) clk = 1'b1;
    #(HalfPeriod) clk = 1'b0;
  end

  header_length_xor_frame_receiver dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_data     (out_data),
    .out_position (out_position)
  );

  hlxfr_frame_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_data      (out_data),
    .out_position  (out_position),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  // Offer one byte from a falling edge; return at the falling edge after it is taken.
  task automatic send_byte(input logic [ByteW-1:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 48);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid = 1'b1;
    in_rx_byte = b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    in_valid = 1'b0;
    while (pending_words != 0) @(negedge clk);
  endtask

  task automatic send_frame(input logic [ByteW-1:0] len, input bit good_sum);
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] payload;
    int count;
    sum = HDR_XOR ^ len;
    send_byte(HDR0);
    send_byte(HDR1);
    send_byte(HDR2);
    send_byte(HDR3);
    send_byte(len);
    send_byte(SEP);
    // a length of zero wraps to 255 payload bytes
    count = (len == '0) ? 255 : int'(len) - 1;
    repeat (count) begin
      payload = ByteW'($urandom);
      sum = sum ^ payload;
      send_byte(payload);
    end
    send_byte(good_sum ? sum : sum ^ ByteW'($urandom_range(1, 255)));
  endtask

  task automatic send_broken();
    logic [ByteW-1:0] hdr [4];
    int k;
    hdr = '{HDR0, HDR1, HDR2, HDR3};
    case ($urandom_range(0, 2))
      0: begin
        // header cut short by a stray byte
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++) send_byte(hdr[i]);
        send_byte(ByteW'($urandom));
      end
      1: begin
        for (int i = 0; i < 4; i++) send_byte(hdr[i]);
        send_byte(ByteW'($urandom_range(1, 20)));
        send_byte(($urandom_range(0, 1) == 0) ? HDR0 : SEP ^ ByteW'($urandom_range(1, 255)));
      end
      default: repeat ($urandom_range(1, 6)) send_byte(ByteW'($urandom));
    endcase
  endtask

  initial begin : result_stalls
    rx_mode_t mode;
    int mode_left;
    int tick;
    mode = RX_ALWAYS;
    mode_left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (hold_done != hold_asked) begin
        hold_done = hold_asked;
        out_ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(32, 200);
      end
      mode_left--;
      tick++;
      case (mode)
        RX_ALWAYS: out_ready = 1'b1;
        RX_RANDOM: out_ready = ($urandom_range(0, 99) < 60);
        default:   out_ready = (tick % 7 != 2) && (tick % 7 != 3);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAIL header_length_xor_frame_receiver");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : byte_source
    int pick;
    logic [ByteW-1:0] len;
    repeat (ResetCycles) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // shortest frame: no payload, good checksum
    send_frame(8'd1, 1'b1);
    // payload extremes with a bad checksum
    send_byte(HDR0);
    send_byte(HDR1);
    send_byte(HDR2);
    send_byte(HDR3);
    send_byte(8'd3);
    send_byte(SEP);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR_XOR ^ 8'd3 ^ 8'hFF ^ 8'h01);
    // mismatches that are retested as a first header byte
    send_byte(HDR0);
    send_byte(HDR0);
    send_byte(HDR1);
    send_byte(HDR2);
    send_byte(HDR0);
    send_byte(HDR1);
    send_byte(HDR2);
    send_byte(HDR3);
    send_byte(8'd2);
    send_byte(HDR0);
    wait_for_drain();

    // fill the block while results are held off
    hold_asked++;
    send_frame(8'd12, 1'b1);
    wait_for_drain();

    send_frame(8'd0, 1'b1);
    send_frame(8'd255, 1'b0);

    while (bytes_sent < ByteTarget) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) hold_asked++;
      if ($urandom_range(0, 49) == 0) wait_for_drain();
      if (pick < 75) begin
        len = ($urandom_range(0, 19) == 0) ? ByteW'($urandom_range(13, 40))
                                           : ByteW'($urandom_range(1, 12));
        send_frame(len, $urandom_range(0, 4) != 0);
      end else begin
        send_broken();
      end
    end

    wait_for_drain();
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS header_length_xor_frame_receiver");
    end else begin
      $display("FAIL header_length_xor_frame_receiver");
    end
    $finish;
  end

endmodule
